@@ rtl/ialu_pkg.sv @@
// shared types and codes for the integer alu with range sum
package ialu_pkg;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_RNG = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_REV = 2'd2;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_MUL,
    MODE_DIV
  } mode_t;

  typedef struct packed {
    logic       vld;
    mode_t      mode;
    logic       neg;
    logic [1:0] status;
  } ctl_t;

endpackage

@@ rtl/ialu_front.sv @@
// input stage: decodes the command and loads the operands for the cell row
module ialu_front
  import ialu_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [2:0]   cmd_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output ctl_t         ctl_o,
  output logic [W-1:0] acc_o,
  output logic [W-1:0] x_o,
  output logic [W-1:0] y_o,
  output logic [W-1:0] u_o,
  output logic [W-1:0] v_o
);

  ctl_t         ctl_r, ctl_nxt;
  logic [W-1:0] acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt, u_r, u_nxt, v_r, v_nxt;
  logic [W-1:0] d, d1, amag, bmag;

  always_comb begin
    d    = b_i - a_i;
    d1   = d + {{(W-1){1'b0}}, 1'b1};
    amag = a_i[W-1] ? (~a_i + {{(W-1){1'b0}}, 1'b1}) : a_i;
    bmag = b_i[W-1] ? (~b_i + {{(W-1){1'b0}}, 1'b1}) : b_i;
    ctl_nxt.vld    = vld_i;
    ctl_nxt.mode   = MODE_PASS;
    ctl_nxt.neg    = 1'b0;
    ctl_nxt.status = ST_OK;
    acc_nxt = '0;
    x_nxt   = '0;
    y_nxt   = '0;
    u_nxt   = '0;
    v_nxt   = '0;
    unique case (cmd_i)
      CMD_ADD: acc_nxt = a_i + b_i;
      CMD_SUB: acc_nxt = a_i - b_i;
      CMD_MUL: begin
        ctl_nxt.mode = MODE_MUL;
        x_nxt = a_i;
        y_nxt = b_i;
      end
      CMD_DIV: begin
        if (b_i == '0) begin
          ctl_nxt.status = ST_DZ;
        end else begin
          ctl_nxt.mode = MODE_DIV;
          ctl_nxt.neg  = a_i[W-1] ^ b_i[W-1];
          x_nxt = bmag;
          y_nxt = amag;
        end
      end
      CMD_RNG: begin
        if ($signed(a_i) > $signed(b_i)) begin
          ctl_nxt.status = ST_REV;
        end else begin
          ctl_nxt.mode = MODE_MUL;
          x_nxt = a_i;
          y_nxt = d1;
          if (!d[0]) begin
            u_nxt = d >> 1;
            v_nxt = d1;
          end else begin
            u_nxt = d;
            v_nxt = (d >> 1) + {{(W-1){1'b0}}, 1'b1};
          end
        end
      end
      default: acc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      u_r   <= u_nxt;
      v_r   <= v_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign u_o   = u_r;
  assign v_o   = v_r;

endmodule

@@ rtl/ialu_cell.sv @@
// one cell of the row: a shift-add multiply step, a restoring divide step, or a plain pass
module ialu_cell
  import ialu_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  ctl_t         ctl_i,
  input  logic [W-1:0] acc_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] u_i,
  input  logic [W-1:0] v_i,
  output ctl_t         ctl_o,
  output logic [W-1:0] acc_o,
  output logic [W-1:0] x_o,
  output logic [W-1:0] y_o,
  output logic [W-1:0] u_o,
  output logic [W-1:0] v_o
);

  ctl_t         ctl_r;
  logic [W-1:0] acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt, u_r, u_nxt, v_r, v_nxt;
  logic [W:0]   t;

  always_comb begin
    t       = {acc_i, y_i[W-1]};
    acc_nxt = acc_i;
    x_nxt   = x_i;
    y_nxt   = y_i;
    u_nxt   = u_i;
    v_nxt   = v_i;
    unique case (ctl_i.mode)
      MODE_MUL: begin
        acc_nxt = acc_i + (y_i[0] ? x_i : '0) + (v_i[0] ? u_i : '0);
        x_nxt   = x_i << 1;
        y_nxt   = y_i >> 1;
        u_nxt   = u_i << 1;
        v_nxt   = v_i >> 1;
      end
      MODE_DIV: begin
        if (t >= {1'b0, x_i}) begin
          acc_nxt = W'(t - {1'b0, x_i});
          y_nxt   = {y_i[W-2:0], 1'b1};
        end else begin
          acc_nxt = t[W-1:0];
          y_nxt   = {y_i[W-2:0], 1'b0};
        end
      end
      default: acc_nxt = acc_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      u_r   <= u_nxt;
      v_r   <= v_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign u_o   = u_r;
  assign v_o   = v_r;

endmodule

@@ rtl/integer_alu_with_range_sum.sv @@
// top level: integer alu with add, subtract, multiply, divide and range sum
//
// input stream: in_tuser carries the command, in_tdata the two operands;
// a word is taken when in_tvalid and in_tready are both high
// output stream: out_tdata carries the wrapped result, out_tuser the status
// (ok, divide by zero, reversed range); one output word per input word
// every word passes from acceptance to out_tvalid through
// one decode stage, a row of DATA_WIDTH cells that each perform one
// multiply bit (two for range sum) or one quotient bit, and the output register
// a new word is accepted every cycle when not stalled; words leave in order
// when the receiver stalls, the whole row holds and in_tready drops in the
// same cycle, so nothing is lost or repeated
// reset clears all valid flags, the row is empty after reset
module integer_alu_with_range_sum
  import ialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  localparam int IN_BITS  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // operand_a, operand_b
  input  logic [IN_BITS-1:0]   in_tdata,
  // cmd
  input  logic [2:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // result
  output logic [OUT_BITS-1:0]  out_tdata,
  // status
  output logic [1:0]           out_tuser
);

  localparam int W        = DATA_WIDTH;

  logic en;
  ctl_t         ctl   [W+1];
  logic [W-1:0] acc   [W+1];
  logic [W-1:0] xs    [W+1];
  logic [W-1:0] ys    [W+1];
  logic [W-1:0] us    [W+1];
  logic [W-1:0] vs    [W+1];

  logic         ovld_r;
  logic [W-1:0] res_r, res_nxt;
  logic [1:0]   st_r;

  assign en        = !ovld_r || out_tready;
  assign in_tready = en;

  ialu_front #(.W(W)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_tvalid),
    .cmd_i (in_tuser),
    .a_i   (in_tdata[W-1:0]),
    .b_i   (in_tdata[2*W-1:W]),
    .ctl_o (ctl[0]),
    .acc_o (acc[0]),
    .x_o   (xs[0]),
    .y_o   (ys[0]),
    .u_o   (us[0]),
    .v_o   (vs[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    ialu_cell #(.W(W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl[i]),
      .acc_i (acc[i]),
      .x_i   (xs[i]),
      .y_i   (ys[i]),
      .u_i   (us[i]),
      .v_i   (vs[i]),
      .ctl_o (ctl[i+1]),
      .acc_o (acc[i+1]),
      .x_o   (xs[i+1]),
      .y_o   (ys[i+1]),
      .u_o   (us[i+1]),
      .v_o   (vs[i+1])
    );
  end

  always_comb begin
    if (ctl[W].mode == MODE_DIV) begin
      res_nxt = ctl[W].neg ? (~ys[W] + {{(W-1){1'b0}}, 1'b1}) : ys[W];
    end else begin
      res_nxt = acc[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= ctl[W].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      st_r  <= ctl[W].status;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = OUT_BITS'(res_r);
  assign out_tuser  = st_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> res_r == '0)
    else $error("error status with nonzero result");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ctl[0].vld)
    else $error("accepted word missing from decode stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl[W].vld) && $stable(ctl[0].vld))
    else $error("row moved while stalled");

endmodule
